// ===== design/env_artifact_stream_validator_assert.svh =====
// Assertion macros used by the stream validator queue.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ENV_ARTIFACT_STREAM_VALIDATOR_ASSERT_SVH
`define ENV_ARTIFACT_STREAM_VALIDATOR_ASSERT_SVH
// property holds at every rising clock edge outside reset
`define ESV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// condition never occurs outside reset
`define ESV_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`endif

// ===== design/esv_pkg.sv =====
// Shared types and constants of the artifact stream validator.
// No dependencies.
package esv_pkg;

  localparam int unsigned HEADER_BYTES   = 60;
  localparam int unsigned MAX_MIP_LEVELS = 32;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_TRUNCATED = 4'd1;
  localparam logic [3:0] ST_MAGIC     = 4'd2;
  localparam logic [3:0] ST_VERSION   = 4'd3;
  localparam logic [3:0] ST_DIMS      = 4'd4;
  localparam logic [3:0] ST_MIPS      = 4'd5;
  localparam logic [3:0] ST_OVERFLOW  = 4'd6;
  localparam logic [3:0] ST_LAYOUT    = 4'd7;
  localparam logic [3:0] ST_NONFINITE = 4'd8;

  localparam logic [1:0] SEC_COEFF = 2'd0;
  localparam logic [1:0] SEC_SPEC  = 2'd1;
  localparam logic [1:0] SEC_LUT   = 2'd2;

  localparam logic [1:0] CFG_SCHEMA  = 2'd0;
  localparam logic [1:0] CFG_MAXDIM  = 2'd1;
  localparam logic [1:0] CFG_COEFF   = 2'd2;

  localparam logic [7:0] MAGIC [8] = '{8'h41, 8'h54, 8'h4C, 8'h45, 8'h4E, 8'h56, 8'h00, 8'h00};

  // one queue entry: results caused by one byte
  typedef struct packed {
    logic        has_word;
    logic [1:0]  sec;
    logic [31:0] value;
    logic        fin;
    logic        has_verd;
    logic [3:0]  status;
    logic [63:0] asset;
  } ent_t;

endpackage

// ===== design/env_artifact_stream_validator.sv =====
// Top level of the artifact stream validator: configuration registers,
// byte parser, result queue and result sender. Depends on esv_pkg.
//
//  channel | signals                              | moves
//  --------+--------------------------------------+------------------------
//  in      | in_valid_i/in_ready_o, byte, last    | one file byte per transfer
//  out     | out_valid_o/out_ready_i, 7 fields    | one result per transfer
//  cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i     | one register write
//
// Header checks finish in the cycle of the byte that completes them. A byte
// with two results (a word and the verdict) takes two output transfers. The
// parser stalls only when the two-entry queue is full; the sender presents
// results from its own register.
// Reset clears all control state; no clearing pass is needed.
module env_artifact_stream_validator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [1:0]  section_o,
  output logic [31:0] word_value_o,
  output logic        word_finite_o,
  output logic [3:0]  status_o,
  output logic [63:0] asset_id_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  logic [31:0] schema_q;
  logic [31:0] maxdim_q;
  logic [10:0] coeff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      schema_q <= 32'd1;
      maxdim_q <= 32'd4096;
      coeff_q  <= 11'd108;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        esv_pkg::CFG_SCHEMA: schema_q <= cfg_wdata_i;
        esv_pkg::CFG_MAXDIM: maxdim_q <= cfg_wdata_i;
        esv_pkg::CFG_COEFF:  coeff_q  <= cfg_wdata_i[10:0];
        default: ;
      endcase
    end
  end

  logic          push, pop, q_valid, q_full;
  esv_pkg::ent_t push_ent, q_head;

  esv_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .in_byte_i        (in_byte_i),
    .in_last_i        (in_last_i),
    .schema_version_i (schema_q),
    .max_dimension_i  (maxdim_q),
    .coeff_bytes_i    (coeff_q),
    .q_full_i         (q_full),
    .push_o           (push),
    .push_ent_o       (push_ent)
  );

  esv_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_ent_i (push_ent),
    .pop_i      (pop),
    .head_o     (q_head),
    .valid_o    (q_valid),
    .full_o     (q_full)
  );

  esv_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_head_i      (q_head),
    .q_pop_o       (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .section_o     (section_o),
    .word_value_o  (word_value_o),
    .word_finite_o (word_finite_o),
    .status_o      (status_o),
    .asset_id_o    (asset_id_o),
    .last_o        (last_o)
  );

endmodule

// ===== design/esv_queue.sv =====
// Two-entry queue between the byte parser and the result sender.
// Depends on esv_pkg and the assertion macro header.
`include "env_artifact_stream_validator_assert.svh"
module esv_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  esv_pkg::ent_t push_ent_i,
  input  logic          pop_i,
  output esv_pkg::ent_t head_o,
  output logic          valid_o,
  output logic          full_o
);

  esv_pkg::ent_t ent_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;

  assign head_o  = ent_q[rd_ptr_q];
  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= push_ent_i;
    end
  end

  `ESV_NEVER(a_cnt_range, cnt_q > 2'd2, "queue count out of range")
  `ESV_NEVER(a_no_overflow, push_i && cnt_q == 2'd2, "push into full queue")
  `ESV_NEVER(a_no_underflow, pop_i && cnt_q == 2'd0, "pop from empty queue")
  `ESV_ASSERT(a_cnt_up, (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 2'd1, "count lost a push")

endmodule

// ===== design/esv_front.sv =====
// Byte parser: magic, version, header fields, dimension and layout checks,
// payload word assembly and verdict. Depends on esv_pkg.
module esv_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  input  logic          in_last_i,
  input  logic [31:0]   schema_version_i,
  input  logic [31:0]   max_dimension_i,
  input  logic [10:0]   coeff_bytes_i,
  input  logic          q_full_i,
  output logic          push_o,
  output esv_pkg::ent_t push_ent_o
);

  localparam logic [32:0] CNT_MAX = '1;
  localparam logic [32:0] HDR33   = 33'(esv_pkg::HEADER_BYTES);

  logic [32:0] cnt_q, cnt_d;
  logic [3:0]  err_q, err_d;
  logic        nf_q, nf_d;
  logic [31:0] wg_q, wg_d;
  logic [63:0] asset_q, asset_d;
  logic [31:0] spec_q, spec_d;
  logic [31:0] lut_q, lut_d;
  logic [31:0] hdr_q [2:10];

  logic        acc, hdr_we;
  logic [3:0]  hdr_idx;
  logic [1:0]  ph;
  logic [31:0] wg_asm;
  esv_pkg::ent_t ent;

  function automatic logic is_pow2(input logic [31:0] v);
    return (v != 32'd0) && ((v & (v - 32'd1)) == 32'd0);
  endfunction

  function automatic logic [4:0] lg2(input logic [31:0] v);
    logic [4:0] r;
    r = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) r = r | 5'(i);
    end
    return r;
  endfunction

  assign in_ready_o = !q_full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign ph         = cnt_q[1:0];
  assign wg_asm     = ((ph == 2'd0) ? 32'd0 : wg_q) | (32'(in_byte_i) << {ph, 3'b000});

  // dimension check, at the byte that completes the lookup height
  logic [31:0] face, mips, lw, lh;
  logic [4:0]  lgf, lgw, lgh;
  logic [5:0]  lgsum;
  logic [3:0]  dims_code;
  logic [31:0] spec_calc, lut_calc;

  always_comb begin
    face  = hdr_q[2];
    mips  = hdr_q[3];
    lw    = hdr_q[4];
    lh    = wg_asm;
    lgf   = lg2(face);
    lgw   = lg2(lw);
    lgh   = lg2(lh);
    lgsum = 6'(lgw) + 6'(lgh);
    if (!is_pow2(face) || !is_pow2(lw) || !is_pow2(lh) || face > max_dimension_i ||
        lw > max_dimension_i || lh > max_dimension_i) begin
      dims_code = esv_pkg::ST_DIMS;
    end else if (mips != 32'(lgf) + 32'd1 ||
                 mips > 32'(esv_pkg::MAX_MIP_LEVELS)) begin
      dims_code = esv_pkg::ST_MIPS;
    end else if (lgf >= 5'd14 || lgsum >= 6'd30) begin
      dims_code = esv_pkg::ST_OVERFLOW;
    end else begin
      dims_code = esv_pkg::ST_OK;
    end
    // sum of 48 * 4^i over all levels is 16 * (4^(log2 face + 1) - 1)
    spec_calc = 32'((((36'd1 << ({1'b0, lgf, 1'b0} + 7'd2)) - 36'd1) << 4));
    lut_calc  = 32'(33'd1 << (7'(lgsum) + 7'd2));
  end

  // layout check, at the last header byte
  logic [11:0] spec_off;
  logic [32:0] lut_off;
  logic        lay_bad;

  always_comb begin
    spec_off = 12'(esv_pkg::HEADER_BYTES) + {1'b0, coeff_bytes_i};
    lut_off  = 33'(spec_off) + 33'(spec_q);
    lay_bad  = (hdr_q[6] != 32'(esv_pkg::HEADER_BYTES)) ||
               (hdr_q[7] != 32'(coeff_bytes_i)) ||
               (hdr_q[8] != 32'(spec_off)) ||
               (hdr_q[9] != spec_q) ||
               ({1'b0, hdr_q[10]} != lut_off) ||
               (wg_asm != lut_q);
  end

  // payload section position
  logic [32:0] rel, r2, r3;
  logic        in_coeff, coeff_word, in_spec, in_lut;

  always_comb begin
    rel        = cnt_q - HDR33;
    r2         = rel - 33'(coeff_bytes_i);
    r3         = r2 - 33'(spec_q);
    in_coeff   = rel < 33'(coeff_bytes_i);
    coeff_word = rel < 33'({coeff_bytes_i[10:2], 2'b00});
    in_spec    = r2 < 33'(spec_q);
    in_lut     = r3 < 33'(lut_q);
  end

  logic [33:0] total;
  logic        half_odd;
  logic [31:0] half_val;

  always_comb begin
    cnt_d   = cnt_q;
    err_d   = err_q;
    nf_d    = nf_q;
    wg_d    = wg_q;
    asset_d = asset_q;
    spec_d  = spec_q;
    lut_d   = lut_q;
    hdr_we  = 1'b0;
    hdr_idx = 4'(cnt_q[5:2] - 4'd3);
    ent     = '0;
    total   = 34'(esv_pkg::HEADER_BYTES) + 34'(coeff_bytes_i) + 34'(spec_q) + 34'(lut_q);
    half_odd = in_spec ? r2[0] : r3[0];
    half_val = {16'd0, in_byte_i, wg_q[7:0]};
    if (acc) begin
      if (cnt_q < 33'd8) begin
        if (in_byte_i != esv_pkg::MAGIC[cnt_q[2:0]] && err_q == esv_pkg::ST_OK) begin
          err_d = esv_pkg::ST_MAGIC;
        end
      end else if (cnt_q < HDR33) begin
        wg_d = wg_asm;
        if (cnt_q >= 33'd12 && cnt_q < 33'd20) begin
          asset_d = asset_q | (64'(in_byte_i) << {cnt_q[2:0] + 3'd4, 3'b000});
        end
        if (ph == 2'd3) begin
          if (cnt_q == 33'd11) begin
            if (wg_asm != schema_version_i && err_q == esv_pkg::ST_OK) begin
              err_d = esv_pkg::ST_VERSION;
            end
          end else if (cnt_q >= 33'd23 && cnt_q <= 33'd55) begin
            hdr_we = 1'b1;
          end
        end
        if (cnt_q == 33'd35 && err_q == esv_pkg::ST_OK) begin
          if (dims_code != esv_pkg::ST_OK) begin
            err_d = dims_code;
          end else begin
            spec_d = spec_calc;
            lut_d  = lut_calc;
          end
        end
        if (cnt_q == HDR33 - 33'd1 && err_q == esv_pkg::ST_OK && lay_bad) begin
          err_d = esv_pkg::ST_LAYOUT;
        end
      end else if (err_q == esv_pkg::ST_OK) begin
        if (in_coeff) begin
          wg_d = wg_asm;
          if (ph == 2'd3 && coeff_word) begin
            ent.has_word = 1'b1;
            ent.sec      = esv_pkg::SEC_COEFF;
            ent.value    = wg_asm;
            ent.fin      = (wg_asm[30:23] != 8'hFF);
          end
        end else if (in_spec || in_lut) begin
          if (!half_odd) begin
            wg_d = {24'd0, in_byte_i};
          end else begin
            ent.has_word = 1'b1;
            ent.sec      = in_spec ? esv_pkg::SEC_SPEC : esv_pkg::SEC_LUT;
            ent.value    = half_val;
            ent.fin      = (in_byte_i[6:2] != 5'h1F);
          end
        end
        if (ent.has_word && !ent.fin) nf_d = 1'b1;
      end
      if (cnt_q != CNT_MAX) cnt_d = cnt_q + 33'd1;
      if (in_last_i) begin
        ent.has_verd = 1'b1;
        ent.asset    = asset_d;
        if (cnt_d < HDR33) begin
          ent.status = esv_pkg::ST_TRUNCATED;
        end else if (err_d != esv_pkg::ST_OK) begin
          ent.status = err_d;
        end else if (cnt_d == CNT_MAX || {1'b0, cnt_d} != total) begin
          ent.status = esv_pkg::ST_LAYOUT;
        end else if (nf_d) begin
          ent.status = esv_pkg::ST_NONFINITE;
        end else begin
          ent.status = esv_pkg::ST_OK;
        end
        cnt_d   = '0;
        err_d   = esv_pkg::ST_OK;
        nf_d    = 1'b0;
        wg_d    = '0;
        asset_d = '0;
        spec_d  = '0;
        lut_d   = '0;
      end
    end
  end

  assign push_o     = acc && (ent.has_word || ent.has_verd);
  assign push_ent_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      err_q   <= esv_pkg::ST_OK;
      nf_q    <= 1'b0;
      wg_q    <= '0;
      asset_q <= '0;
      spec_q  <= '0;
      lut_q   <= '0;
    end else begin
      cnt_q   <= cnt_d;
      err_q   <= err_d;
      nf_q    <= nf_d;
      wg_q    <= wg_d;
      asset_q <= asset_d;
      spec_q  <= spec_d;
      lut_q   <= lut_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_q[hdr_idx] <= wg_asm;
    end
  end

endmodule

// ===== design/esv_back.sv =====
// Result sender: takes queue entries and presents word and verdict
// results on the output channel. Depends on esv_pkg.
module esv_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  esv_pkg::ent_t q_head_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          kind_o,
  output logic [1:0]    section_o,
  output logic [31:0]   word_value_o,
  output logic          word_finite_o,
  output logic [3:0]    status_o,
  output logic [63:0]   asset_id_o,
  output logic          last_o
);

  esv_pkg::ent_t cur_q;
  logic          busy_q, busy_d;
  logic          vph_q, vph_d;   // 1 while the verdict is shown
  logic          xfer, done, load;

  assign xfer    = busy_q && out_ready_i;
  assign done    = xfer && (vph_q || !cur_q.has_verd);
  assign load    = (!busy_q || done) && q_valid_i;
  assign q_pop_o = load;

  always_comb begin
    busy_d = busy_q;
    vph_d  = vph_q;
    if (xfer) begin
      if (done) busy_d = 1'b0;
      else vph_d = 1'b1;
    end
    if (load) begin
      busy_d = 1'b1;
      vph_d  = !q_head_i.has_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      vph_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      vph_q  <= vph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) cur_q <= q_head_i;
  end

  assign out_valid_o   = busy_q;
  assign kind_o        = vph_q;
  assign section_o     = vph_q ? esv_pkg::SEC_COEFF : cur_q.sec;
  assign word_value_o  = vph_q ? 32'd0 : cur_q.value;
  assign word_finite_o = vph_q ? 1'b0 : cur_q.fin;
  assign status_o      = vph_q ? cur_q.status : esv_pkg::ST_OK;
  assign asset_id_o    = vph_q ? cur_q.asset : 64'd0;
  assign last_o        = vph_q || !cur_q.has_verd;

endmodule

// ===== tb/tb_env_artifact_stream_validator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for env_artifact_stream_validator: builds artifact files,
// predicts payload words and verdicts in a scoreboard class. Depends on esv_pkg.
module tb_env_artifact_stream_validator;

  localparam longint unsigned ALL64 = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic        kind;
    logic [1:0]  sec;
    logic [31:0] value;
    logic        fin;
    logic [3:0]  status;
    logic [63:0] asset;
    logic        last;
  } result_t;

  typedef enum int {F_GOOD, F_FLIP, F_TRUNC, F_EXTRA, F_SHORT, F_DIMS, F_MIPS, F_FIELD}
    file_mode_e;

  class artifact_scoreboard;
    bit [31:0]       schema, maxdim;
    bit [10:0]       coeff;
    bit [32:0]       cnt;
    bit [31:0]       hdr[12];
    bit [63:0]       asset;
    bit [31:0]       gather;
    bit [3:0]        first_err;
    bit              nonfin;
    longint unsigned spec_bytes, lut_bytes;
    result_t         pending_q[$];
    int              errors;

    function new();
      schema = 1;
      maxdim = 4096;
      coeff = 108;
      errors = 0;
      clear_file();
    endfunction

    function void clear_file();
      cnt = 0;
      foreach (hdr[i]) hdr[i] = 0;
      asset = 0;
      gather = 0;
      first_err = esv_pkg::ST_OK;
      nonfin = 0;
      spec_bytes = 0;
      lut_bytes = 0;
    endfunction

    function void set_cfg(logic [1:0] idx, bit [31:0] val);
      case (idx)
        esv_pkg::CFG_SCHEMA: schema = val;
        esv_pkg::CFG_MAXDIM: maxdim = val;
        esv_pkg::CFG_COEFF:  coeff = val[10:0];
        default: ;
      endcase
    endfunction

    function bit is_pow2(bit [31:0] v);
      return v != 0 && (v & (v - 1)) == 0;
    endfunction

    function void flag(bit [3:0] code);
      if (first_err == esv_pkg::ST_OK) first_err = code;
    endfunction

    function void check_dims();
      bit [31:0]       face, mips, w, h;
      longint unsigned spec, m, texels, lvl, lut;
      int              bl;
      face = hdr[2];
      mips = hdr[3];
      w = hdr[4];
      h = hdr[5];
      if (!is_pow2(face) || !is_pow2(w) || !is_pow2(h) || face > maxdim ||
          w > maxdim || h > maxdim) begin
        flag(esv_pkg::ST_DIMS);
        return;
      end
      bl = 0;
      for (int i = 0; i < 32; i++) if (face[i]) bl = i + 1;
      if (mips != bl || mips > esv_pkg::MAX_MIP_LEVELS) begin
        flag(esv_pkg::ST_MIPS);
        return;
      end
      spec = 0;
      m = face;
      for (int i = 0; i < mips && i < esv_pkg::MAX_MIP_LEVELS; i++) begin
        texels = m * m;
        if (texels > ALL64 / 48) begin
          flag(esv_pkg::ST_OVERFLOW);
          return;
        end
        lvl = texels * 48;
        if (spec > ALL64 - lvl) begin
          flag(esv_pkg::ST_OVERFLOW);
          return;
        end
        spec += lvl;
        m = (m > 1) ? m / 2 : 1;
      end
      texels = {32'd0, w} * {32'd0, h};
      if (texels > ALL64 / 4) begin
        flag(esv_pkg::ST_OVERFLOW);
        return;
      end
      lut = texels * 4;
      if (spec > 64'hFFFF_FFFF || lut > 64'hFFFF_FFFF) begin
        flag(esv_pkg::ST_OVERFLOW);
        return;
      end
      spec_bytes = spec;
      lut_bytes = lut;
    endfunction

    function void check_layout();
      longint unsigned spec_off, lut_off;
      spec_off = esv_pkg::HEADER_BYTES + coeff;
      lut_off = spec_off + spec_bytes;
      if (hdr[6] != esv_pkg::HEADER_BYTES || hdr[7] != coeff || hdr[8] != spec_off ||
          hdr[9] != spec_bytes || hdr[10] != lut_off || hdr[11] != lut_bytes)
        flag(esv_pkg::ST_LAYOUT);
    endfunction

    function void add_word(logic [1:0] sec, bit [31:0] v, bit fin);
      result_t r;
      r = '0;
      r.sec = sec;
      r.value = v;
      r.fin = fin;
      if (!fin) nonfin = 1;
      pending_q = {pending_q, r};
    endfunction

    // one accepted byte transfer
    function void note_byte(bit [7:0] b, bit lst);
      longint unsigned pos, rel, r2, total;
      bit [1:0]        ph, sec;
      bit [15:0]       hv;
      bit [3:0]        st;
      int              n0;
      result_t         r;
      pos = cnt;
      n0 = pending_q.size();
      if (pos < 8) begin
        if (b != esv_pkg::MAGIC[pos]) flag(esv_pkg::ST_MAGIC);
      end else if (pos < esv_pkg::HEADER_BYTES) begin
        ph = pos[1:0];
        if (ph == 0) gather = 0;
        gather |= b << (8 * ph);
        if (pos >= 12 && pos < 20) asset |= 64'(b) << (8 * (pos - 12));
        if (ph == 3) begin
          if (pos == 11) begin
            if (gather != schema) flag(esv_pkg::ST_VERSION);
          end else hdr[(pos >> 2) - 3] = gather;
        end
        if (pos == 35 && first_err == esv_pkg::ST_OK) check_dims();
        if (pos == esv_pkg::HEADER_BYTES - 1 && first_err == esv_pkg::ST_OK) check_layout();
      end else if (first_err == esv_pkg::ST_OK) begin
        rel = pos - esv_pkg::HEADER_BYTES;
        if (rel < coeff) begin
          ph = rel[1:0];
          if (ph == 0) gather = 0;
          gather |= b << (8 * ph);
          if (ph == 3 && rel < (coeff & ~11'd3))
            add_word(esv_pkg::SEC_COEFF, gather, gather[30:23] != 8'hFF);
        end else begin
          r2 = rel - coeff;
          sec = 2'd3;
          if (r2 < spec_bytes) sec = esv_pkg::SEC_SPEC;
          else if (r2 - spec_bytes < lut_bytes) begin
            sec = esv_pkg::SEC_LUT;
            r2 -= spec_bytes;
          end
          if (sec != 2'd3) begin
            if (r2[0] == 0) gather = b;
            else begin
              hv = {b, gather[7:0]};
              add_word(sec, {16'd0, hv}, (hv & 16'h7C00) != 16'h7C00);
            end
          end
        end
      end
      if (cnt != '1) cnt++;
      if (lst) begin
        total = esv_pkg::HEADER_BYTES + coeff + spec_bytes + lut_bytes;
        if (cnt < esv_pkg::HEADER_BYTES) st = esv_pkg::ST_TRUNCATED;
        else if (first_err != esv_pkg::ST_OK) st = first_err;
        else if (cnt == '1 || cnt != total) st = esv_pkg::ST_LAYOUT;
        else if (nonfin) st = esv_pkg::ST_NONFINITE;
        else st = esv_pkg::ST_OK;
        r = '0;
        r.kind = 1;
        r.status = st;
        r.asset = asset;
        pending_q = {pending_q, r};
        clear_file();
      end
      if (pending_q.size() > n0) pending_q[pending_q.size() - 1].last = 1;
    endfunction

    function void cmp(string name, longint unsigned e, longint unsigned a);
      if (e != a) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (pending_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      cmp("kind", e.kind, got.kind);
      cmp("section", e.sec, got.sec);
      cmp("word_value", e.value, got.value);
      cmp("word_finite", e.fin, got.fin);
      cmp("status", e.status, got.status);
      cmp("asset_id", e.asset, got.asset);
      cmp("last", e.last, got.last);
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid = 0;
  logic        in_ready_o;
  logic [7:0]  in_byte = 0;
  logic        in_last = 0;
  logic        out_valid_o;
  logic        out_ready = 0;
  logic        kind_o;
  logic [1:0]  section_o;
  logic [31:0] word_value_o;
  logic        word_finite_o;
  logic [3:0]  status_o;
  logic [63:0] asset_id_o;
  logic        last_o;
  logic        cfg_we = 0;
  logic [1:0]  cfg_idx = esv_pkg::CFG_SCHEMA;
  logic [31:0] cfg_wdata = 0;

  artifact_scoreboard sb = new();
  int        bytes_sent = 0;
  int        stall_cycles = 0;
  int        hold_left = 0;
  bit        hold_req = 0, hold_done = 0;
  bit [31:0] cur_schema = 1, cur_maxdim = 4096;
  bit [10:0] cur_coeff = 108;

  always #4 clk_i = ~clk_i;

  env_artifact_stream_validator DUT (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o, .in_byte_i(in_byte), .in_last_i(in_last),
    .out_valid_o, .out_ready_i(out_ready),
    .kind_o, .section_o, .word_value_o, .word_finite_o, .status_o, .asset_id_o, .last_o,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  // idle percentages by stage of the run
  function int tx_idle_pct();
    return bytes_sent < 300 ? 10 : bytes_sent < 600 ? 56 : 0;
  endfunction

  function int rx_idle_pct();
    return bytes_sent < 300 ? 56 : bytes_sent < 600 ? 10 : 0;
  endfunction

  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done = 1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 0;
    end else out_ready <= ($urandom_range(99) >= rx_idle_pct());
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready)
      sb.check_result({kind_o, section_o, word_value_o, word_finite_o, status_o,
                       asset_id_o, last_o});
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) stall_cycles = 0;
    else if (rst_ni) stall_cycles++;
    if (stall_cycles >= 4000) begin
      $display("env_artifact_stream_validator: mismatch");
      $finish;
    end
  end

  task automatic send_byte(bit [7:0] b, bit l);
    while ($urandom_range(99) < tx_idle_pct()) begin
      in_valid <= 0;
      @(negedge clk_i);
    end
    in_valid <= 1;
    in_byte <= b;
    in_last <= l;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(b, l);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // sender pauses until every expected result is back
  task automatic drain();
    in_valid <= 0;
    do @(negedge clk_i); while (sb.pending() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, bit [31:0] val);
    drain();
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    sb.set_cfg(idx, val);
    case (idx)
      esv_pkg::CFG_SCHEMA: cur_schema = val;
      esv_pkg::CFG_MAXDIM: cur_maxdim = val;
      esv_pkg::CFG_COEFF:  cur_coeff = val[10:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 0;
  endtask

  function automatic void push_word(ref bit [7:0] q[$], input bit [31:0] w);
    for (int i = 0; i < 4; i++) q = {q, w[8*i +: 8]};
  endfunction

  // clean: keep exponent bits of every payload word away from all ones
  task automatic send_file(int fk, int wk, int hk, file_mode_e mode, bit clean);
    bit [7:0]        f[$];
    bit [31:0]       face, w, h;
    longint unsigned spec, lut, m, payload, rel;
    int              cut;
    bit [7:0]        b;
    face = 32'd1 << fk;
    w = (mode == F_DIMS) ? 32'd3 : 32'd1 << wk;
    h = 32'd1 << hk;
    spec = 0;
    m = face;
    for (int i = 0; i <= fk; i++) begin
      spec += m * m * 48;
      m = (m > 1) ? m / 2 : 1;
    end
    lut = {32'd0, w} * {32'd0, h} * 4;
    foreach (esv_pkg::MAGIC[i]) f = {f, esv_pkg::MAGIC[i]};
    push_word(f, cur_schema);
    push_word(f, $urandom);
    push_word(f, $urandom);
    push_word(f, face);
    push_word(f, fk + 1 + (mode == F_MIPS ? $urandom_range(1, 2) : 0));
    push_word(f, w);
    push_word(f, h);
    push_word(f, esv_pkg::HEADER_BYTES);
    push_word(f, cur_coeff);
    push_word(f, esv_pkg::HEADER_BYTES + cur_coeff);
    push_word(f, spec);
    push_word(f, esv_pkg::HEADER_BYTES + cur_coeff + spec);
    push_word(f, lut);
    if (mode == F_FLIP) f[$urandom_range(0, 59)] ^= 8'($urandom_range(1, 255));
    if (mode == F_FIELD) f[$urandom_range(36, 59)] ^= 8'(1 << $urandom_range(0, 7));
    payload = cur_coeff + spec + lut;
    // header errors hold over any payload, so a short tail is enough there
    if (payload > 600 || mode == F_FLIP || mode == F_DIMS || mode == F_MIPS ||
        mode == F_FIELD)
      payload = $urandom_range(0, 20);
    for (rel = 0; rel < payload; rel++) begin
      b = $urandom;
      if (clean && (rel < cur_coeff ? rel[1:0] == 3 : rel[0] != cur_coeff[0])) b[6] = 0;
      f = {f, b};
    end
    if (mode == F_TRUNC) begin
      cut = $urandom_range(1, f.size() - 1);
      while (f.size() > cut) void'(f.pop_back());
    end
    if (mode == F_SHORT) repeat ($urandom_range(1, 3)) void'(f.pop_back());
    if (mode == F_EXTRA) repeat ($urandom_range(1, 6)) f = {f, 8'($urandom)};
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
  endtask

  initial begin
    int p;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // reset configuration; receiver held off so the block fills and stalls
    hold_req = 1;
    send_file(0, 0, 0, F_GOOD, 1);
    write_cfg(esv_pkg::CFG_MAXDIM, 32'h8000_0000);
    write_cfg(esv_pkg::CFG_SCHEMA, 32'd0);
    write_cfg(esv_pkg::CFG_COEFF, 32'd4);
    send_file(31, 0, 0, F_GOOD, 1);   // mip level size overflows
    send_file(14, 0, 0, F_GOOD, 1);   // specular total above 32 bits
    send_file(0, 31, 31, F_GOOD, 1);  // lookup table size overflows
    send_file(0, 1, 1, F_GOOD, 0);

    p = 0;
    while (bytes_sent < 860) begin
      file_mode_e mode;
      write_cfg(esv_pkg::CFG_SCHEMA,
                p % 3 == 0 ? 32'hFFFF_FFFF : p % 3 == 1 ? 32'd1 : $urandom);
      write_cfg(esv_pkg::CFG_MAXDIM, p % 4 == 0 ? 32'd1 : p % 4 == 1 ? 32'h8000_0000 :
                                     $urandom_range(1, 16));
      write_cfg(esv_pkg::CFG_COEFF,
                p == 1 ? 32'd7 : p == 2 ? 32'd1024 : $urandom_range(4, 24));
      mode = ($urandom_range(99) < 50) ? F_GOOD : file_mode_e'($urandom_range(1, 7));
      send_file(($urandom_range(3) == 0) ? 1 : 0, $urandom_range(0, 1),
                $urandom_range(0, 1), mode, $urandom_range(1));
      p++;
    end

    drain();
    repeat (20) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("env_artifact_stream_validator: match");
    end else begin
      $display("env_artifact_stream_validator: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/esv_pkg.sv
design/esv_queue.sv
design/esv_front.sv
design/esv_back.sv
design/env_artifact_stream_validator.sv
tb/tb_env_artifact_stream_validator.sv
